### rtl/core/three_channel_interval_timer_core_macros.svh
// Assertion macros used by the interval timer core top level.
`ifndef THREE_CHANNEL_INTERVAL_TIMER_CORE_MACROS_SVH
`define THREE_CHANNEL_INTERVAL_TIMER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCIT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/tcit_pkg.sv
// Types, codes and helpers for the three-channel interval timer core.
`timescale 1ns / 1ps
`default_nettype none

package tcit_pkg;

    localparam int NUM_CH   = 3;
    localparam int GATED_CH = 2;

    // Request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_GATE  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Port offsets
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // Access modes from control word bits 5:4
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LSB   = 2'd1;
    localparam logic [1:0] ACC_MSB   = 2'd2;
    localparam logic [1:0] ACC_BOTH  = 2'd3;

    // Control word field used to skip a write
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam logic [7:0]  CTRL_READ_VAL = 8'hFF;
    localparam logic [15:0] ZERO_HALF     = 16'h8000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] port_sel;
        logic [7:0] write_data;
        logic       gate_level;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ch0_rose;
        logic       out0_level;
        logic       out1_level;
        logic       out2_level;
    } t_rsp;

    // Half period for a loaded count: max(1, n/2), 0x8000 for zero.
    function automatic logic [15:0] half_of(input logic [15:0] n);
        logic [15:0] h;
        h = {1'b0, n[15:1]};
        if (n == 16'd0) begin
            h = ZERO_HALF;
        end else if (h == 16'd0) begin
            h = 16'd1;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### rtl/core/three_channel_interval_timer_core.sv
// Top level of the three-channel square-wave interval timer core.
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle; input ready drops only while a result
//   beat is held and the output side is not taking it.
// Reset (i_rst_n low, synchronous): all channels stop with outputs high,
//   counts, latches and byte flags clear, gate 2 low, output register empty.
`timescale 1ns / 1ps
`default_nettype none

`include "three_channel_interval_timer_core_macros.svh"

module three_channel_interval_timer_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tcit_pkg::t_req   i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tcit_pkg::t_rsp        o_out_data
);

    localparam int NC = tcit_pkg::NUM_CH;

    // Per-channel timer state
    logic [15:0] r_count       [NC];
    logic [15:0] n_count       [NC];
    logic [15:0] r_half        [NC];
    logic [15:0] n_half        [NC];
    logic [15:0] r_latched     [NC];
    logic [15:0] n_latched     [NC];
    logic [7:0]  r_low_hold    [NC];
    logic [7:0]  n_low_hold    [NC];
    logic [1:0]  r_mode        [NC];
    logic [1:0]  n_mode        [NC];
    logic [NC-1:0] r_running, n_running;
    logic [NC-1:0] r_out_lvl, n_out_lvl;
    logic [NC-1:0] r_latch_held, n_latch_held;
    logic [NC-1:0] r_latch_hi, n_latch_hi;
    logic [NC-1:0] r_data_hi, n_data_hi;
    logic          r_gate, n_gate;

    // Output register
    logic            r_out_valid;
    tcit_pkg::t_rsp  r_out_data;
    tcit_pkg::t_rsp  n_rsp;

    logic in_accept;

    // The output register parts the two sides: take a new beat whenever the
    // held result is gone or is leaving this cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Single pass over the request: every channel decides its own next state
    // from the request fields and its current registers.
    always_comb begin
        logic [15:0] base;
        logic [15:0] dec;
        logic [15:0] load_val;
        logic        do_load;
        logic        sel;
        logic        ctrl_sel;
        logic [7:0]  rd;
        logic        rose;

        rd   = 8'd0;
        rose = 1'b0;
        n_gate = r_gate;
        n_running    = r_running;
        n_out_lvl    = r_out_lvl;
        n_latch_held = r_latch_held;
        n_latch_hi   = r_latch_hi;
        n_data_hi    = r_data_hi;

        if (i_in_data.req_type == tcit_pkg::REQ_READ
                && i_in_data.port_sel == tcit_pkg::PORT_CTRL) begin
            rd = tcit_pkg::CTRL_READ_VAL;
        end
        if (i_in_data.req_type == tcit_pkg::REQ_GATE) begin
            n_gate = i_in_data.gate_level;
        end

        for (int c = 0; c < NC; c++) begin
            n_count[c]    = r_count[c];
            n_half[c]     = r_half[c];
            n_latched[c]  = r_latched[c];
            n_low_hold[c] = r_low_hold[c];
            n_mode[c]     = r_mode[c];

            sel      = (i_in_data.port_sel == 2'(c));
            ctrl_sel = (i_in_data.write_data[7:6] == 2'(c));
            do_load  = 1'b0;
            load_val = 16'd0;
            base     = (r_count[c] == 16'd0) ? r_half[c] : r_count[c];
            dec      = base - 16'd1;

            case (i_in_data.req_type)
                tcit_pkg::REQ_READ: begin
                    if (sel) begin
                        if (r_latch_held[c]) begin
                            if (r_mode[c] == tcit_pkg::ACC_MSB) begin
                                n_latch_held[c] = 1'b0;
                                rd = r_latched[c][15:8];
                            end else if (r_mode[c] == tcit_pkg::ACC_LSB) begin
                                n_latch_held[c] = 1'b0;
                                rd = r_latched[c][7:0];
                            end else if (!r_latch_hi[c]) begin
                                n_latch_hi[c] = 1'b1;
                                rd = r_latched[c][7:0];
                            end else begin
                                n_latch_held[c] = 1'b0;
                                n_latch_hi[c]   = 1'b0;
                                rd = r_latched[c][15:8];
                            end
                        end else if (r_mode[c] == tcit_pkg::ACC_MSB) begin
                            rd = r_count[c][15:8];
                        end else if (r_mode[c] == tcit_pkg::ACC_LSB) begin
                            rd = r_count[c][7:0];
                        end else begin
                            // shared byte flag with writes
                            n_data_hi[c] = !r_data_hi[c];
                            rd = r_data_hi[c] ? r_count[c][15:8] : r_count[c][7:0];
                        end
                    end
                end
                tcit_pkg::REQ_WRITE: begin
                    if (i_in_data.port_sel == tcit_pkg::PORT_CTRL) begin
                        if (ctrl_sel && i_in_data.write_data[7:6] != tcit_pkg::CH_NONE) begin
                            if (i_in_data.write_data[5:4] == tcit_pkg::ACC_LATCH) begin
                                n_latch_held[c] = 1'b1;
                                n_latched[c]    = r_count[c];
                                n_latch_hi[c]   = 1'b0;
                            end else begin
                                n_mode[c]    = i_in_data.write_data[5:4];
                                n_data_hi[c] = 1'b0;
                                n_running[c] = 1'b0;
                            end
                        end
                    end else if (sel) begin
                        if (r_mode[c] == tcit_pkg::ACC_LSB) begin
                            do_load  = 1'b1;
                            load_val = {8'd0, i_in_data.write_data};
                        end else if (r_mode[c] == tcit_pkg::ACC_MSB) begin
                            do_load  = 1'b1;
                            load_val = {i_in_data.write_data, 8'd0};
                        end else if (!r_data_hi[c]) begin
                            n_low_hold[c] = i_in_data.write_data;
                            n_data_hi[c]  = 1'b1;
                        end else begin
                            do_load      = 1'b1;
                            load_val     = {i_in_data.write_data, r_low_hold[c]};
                            n_data_hi[c] = 1'b0;
                        end
                    end
                end
                tcit_pkg::REQ_GATE: begin
                    if (c == tcit_pkg::GATED_CH) begin
                        if (!i_in_data.gate_level) begin
                            n_out_lvl[c] = 1'b1;
                        end else if (!r_gate) begin
                            n_count[c] = r_half[c];
                        end
                    end
                end
                tcit_pkg::REQ_TICK: begin
                    if (r_running[c] && (c != tcit_pkg::GATED_CH || r_gate)) begin
                        n_count[c] = dec;
                        if (dec == 16'd0) begin
                            n_out_lvl[c] = !r_out_lvl[c];
                            if (c == 0) begin
                                rose = !r_out_lvl[c];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (do_load) begin
                n_half[c]    = tcit_pkg::half_of(load_val);
                n_count[c]   = tcit_pkg::half_of(load_val);
                n_running[c] = 1'b1;
                n_out_lvl[c] = 1'b1;
            end
        end

        n_rsp.read_data  = rd;
        n_rsp.ch0_rose   = rose;
        n_rsp.out0_level = n_out_lvl[0];
        n_rsp.out1_level = n_out_lvl[1];
        n_rsp.out2_level = n_out_lvl[2];
    end

    // Hold state between beats; advance it only on an accepted request beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NC; c++) begin
                r_count[c]    <= 16'd0;
                r_half[c]     <= 16'd0;
                r_latched[c]  <= 16'd0;
                r_low_hold[c] <= 8'd0;
                r_mode[c]     <= tcit_pkg::ACC_LATCH;
            end
            r_running    <= '0;
            r_out_lvl    <= '1;
            r_latch_held <= '0;
            r_latch_hi   <= '0;
            r_data_hi    <= '0;
            r_gate       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count      <= n_count;
                r_half       <= n_half;
                r_latched    <= n_latched;
                r_low_hold   <= n_low_hold;
                r_mode       <= n_mode;
                r_running    <= n_running;
                r_out_lvl    <= n_out_lvl;
                r_latch_held <= n_latch_held;
                r_latch_hi   <= n_latch_hi;
                r_data_hi    <= n_data_hi;
                r_gate       <= n_gate;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                // drop the result beat once it is taken
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset: it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_rsp;
        end
    end

    `TCIT_ASSERT_ALWAYS(a_reset_empties_out, !i_rst_n |=> !o_out_valid, "result beat after reset")
    `TCIT_ASSERT(a_ctrl_read_ff, (in_accept && i_in_data.req_type == tcit_pkg::REQ_READ && i_in_data.port_sel == tcit_pkg::PORT_CTRL) |=> (o_out_valid && o_out_data.read_data == tcit_pkg::CTRL_READ_VAL), "control port read not 0xFF")
    `TCIT_ASSERT(a_nonread_zero, (in_accept && i_in_data.req_type != tcit_pkg::REQ_READ) |=> (o_out_data.read_data == 8'd0), "read data nonzero on a non-read")
    `TCIT_ASSERT(a_gate_low_out_high, !r_gate |-> r_out_lvl[tcit_pkg::GATED_CH], "channel 2 low with gate low")
    `TCIT_ASSERT(a_levels_match, o_out_valid |-> (o_out_data.out0_level == r_out_lvl[0] && o_out_data.out1_level == r_out_lvl[1] && o_out_data.out2_level == r_out_lvl[2]), "result levels differ from state")
    `TCIT_ASSERT(a_rose_high, (o_out_valid && o_out_data.ch0_rose) |-> o_out_data.out0_level, "rise reported with channel 0 low")

endmodule

`default_nettype wire
